### hdl/fcma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcma_pkg;

  // channel and sample geometry
  localparam int CHANNELS = 4;
  localparam int SAMPLE_W = 12;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // history ring, one row per averaging step
  localparam int HIST_DEPTH = 256;
  localparam int PTR_W = $clog2(HIST_DEPTH);

  // running sums wrap at this width, top bit is the sign
  localparam int SUM_W = SAMPLE_W + 11;

  // windows and their log2
  localparam int FAST_CV_WIN = 8;
  localparam int FAST_KNOB_WIN = 64;
  localparam int CV_FAST_SHIFT_I = $clog2(FAST_CV_WIN);
  localparam int KNOB_FAST_SHIFT_I = $clog2(FAST_KNOB_WIN);
  localparam int HIST_SHIFT_I = $clog2(HIST_DEPTH);
  localparam int SHIFT_W = $clog2(HIST_SHIFT_I + 1);
  localparam logic [SHIFT_W-1:0] CV_FAST_SHIFT = SHIFT_W'(CV_FAST_SHIFT_I);
  localparam logic [SHIFT_W-1:0] KNOB_FAST_SHIFT = SHIFT_W'(KNOB_FAST_SHIFT_I);
  localparam logic [SHIFT_W-1:0] HIST_SHIFT = SHIFT_W'(HIST_SHIFT_I);

  // read offsets back into the ring
  localparam logic [PTR_W-1:0] CV_FAST_OFS = PTR_W'(FAST_CV_WIN);
  localparam logic [PTR_W-1:0] KNOB_FAST_OFS = PTR_W'(FAST_KNOB_WIN);
  localparam logic [PTR_W-1:0] HIST_OFS = PTR_W'(HIST_DEPTH);

  // scan pre-averaging
  localparam int SCANS = 4;
  localparam int SCAN_SHIFT = $clog2(SCANS);
  localparam int SCAN_CNT_W = $clog2(SCANS);
  localparam int ACC_W = SAMPLE_W + SCAN_SHIFT;
  localparam logic [SCAN_CNT_W-1:0] SCAN_LAST = SCAN_CNT_W'(SCANS - 1);

  // smoothing modes
  localparam logic [1:0] MODE_FAST = 2'd0;
  localparam logic [1:0] MODE_SLOW = 2'd1;
  localparam logic [1:0] MODE_PREAVG = 2'd2;

  // register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_SMOOTHING_MODE = 1'b0;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // stage 0 request to a lane: history access for one averaging step
  typedef struct packed {
    logic fire;
    logic [PTR_W-1:0] wr_addr;
    logic [PTR_W-1:0] rd_addr;
    logic [SHIFT_W-1:0] shift;
  } lane_req_t;

  // stage 1 control to a lane
  typedef struct packed {
    logic go;
    logic hit;
  } lane_s1_t;

endpackage

`default_nettype wire

### hdl/fcma_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fcma_front (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic [1:0]                                smoothing_mode,
  input  wire logic                                      sample_valid,
  output logic                                           sample_ready,
  input  wire fcma_pkg::sample_t [fcma_pkg::CHANNELS-1:0] scan,
  input  wire logic                                      out_free,
  output fcma_pkg::sample_t [fcma_pkg::CHANNELS-1:0]      step_val,
  output fcma_pkg::lane_req_t                            cv_req,
  output fcma_pkg::lane_req_t                            knob_req,
  output fcma_pkg::lane_s1_t                             cv_s1,
  output fcma_pkg::lane_s1_t                             knob_s1
);
  import fcma_pkg::*;

  logic [PTR_W-1:0] ptr;
  logic [HIST_DEPTH-1:0] row_vld;
  logic [ACC_W-1:0] scan_acc [CHANNELS];
  logic [SCAN_CNT_W-1:0] scan_count;
  logic s1_valid;
  logic cv_hit;
  logic knob_hit;

  logic fast;
  logic preavg;
  logic group_done;
  logic accept;
  logic step_fire;
  logic s1_go;
  logic [ACC_W-1:0] acc_sum [CHANNELS];
  sample_t avg [CHANNELS];

  // handshake and step decision
  always_comb begin
    fast = (smoothing_mode == MODE_FAST);
    preavg = (smoothing_mode == MODE_PREAVG);
    group_done = (scan_count == SCAN_LAST);
    sample_ready = !s1_valid || out_free;
    accept = sample_valid && sample_ready;
    step_fire = accept && (!preavg || group_done);
    s1_go = s1_valid && out_free;
  end

  // scan sums and the value that enters the window
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      acc_sum[c] = scan_acc[c] + ACC_W'(scan[c]);
      avg[c] = SAMPLE_W'(acc_sum[c] >> SCAN_SHIFT);
      step_val[c] = preavg ? avg[c] : scan[c];
    end
    // cv is inverted after pre-averaging
    if (preavg) begin
      step_val[0] = SAMPLE_MAX - avg[0];
    end
  end

  // history access per lane group
  always_comb begin
    cv_req.fire = step_fire;
    cv_req.wr_addr = ptr;
    cv_req.rd_addr = ptr - (fast ? CV_FAST_OFS : HIST_OFS);
    cv_req.shift = fast ? CV_FAST_SHIFT : HIST_SHIFT;
    knob_req.fire = step_fire;
    knob_req.wr_addr = ptr;
    knob_req.rd_addr = ptr - (fast ? KNOB_FAST_OFS : HIST_OFS);
    knob_req.shift = fast ? KNOB_FAST_SHIFT : HIST_SHIFT;
    cv_s1.go = s1_go;
    cv_s1.hit = cv_hit;
    knob_s1.go = s1_go;
    knob_s1.hit = knob_hit;
  end

  // pointer, row valid bits, stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      row_vld <= '0;
      s1_valid <= 1'b0;
      cv_hit <= 1'b0;
      knob_hit <= 1'b0;
    end else begin
      if (step_fire) begin
        ptr <= ptr + 1'b1;
        row_vld[ptr] <= 1'b1;
        cv_hit <= row_vld[cv_req.rd_addr];
        knob_hit <= row_vld[knob_req.rd_addr];
      end
      if (step_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // pre-averaging accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_count <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        scan_acc[c] <= '0;
      end
    end else if (accept && preavg) begin
      if (group_done) begin
        scan_count <= '0;
        for (int c = 0; c < CHANNELS; c++) begin
          scan_acc[c] <= '0;
        end
      end else begin
        scan_count <= scan_count + 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
          scan_acc[c] <= acc_sum[c];
        end
      end
    end
  end

  // a stalled step stays in stage 1
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid)
    else $error("stage 1 step dropped while stalled");

  // no new step enters while stage 1 is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |-> !step_fire)
    else $error("step issued over a stalled stage 1");

  // the ring pointer moves by one row per step
  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    step_fire |=> ptr == PTR_W'($past(ptr) + 1'b1))
    else $error("history pointer did not advance by one");

  // pre-averaging steps only on a completed group
  a_group: assert property (@(posedge clk) disable iff (rst)
    step_fire && preavg |-> scan_count == SCAN_LAST)
    else $error("pre-averaged step before the group completed");

endmodule

`default_nettype wire

### hdl/fcma_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module fcma_lane (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fcma_pkg::lane_req_t req,
  input  wire fcma_pkg::sample_t   val,
  input  wire fcma_pkg::lane_s1_t  s1,
  output fcma_pkg::sample_t        result
);
  import fcma_pkg::*;

  sample_t hist [HIST_DEPTH];
  sample_t rd_data;
  sample_t val1;
  logic [SHIFT_W-1:0] shift1;
  logic [SUM_W-1:0] sum;

  sample_t leaving;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] quot;

  // history ring: read the leaving sample, write the new one
  always_ff @(posedge clk) begin
    if (req.fire) begin
      rd_data <= hist[req.rd_addr];
      hist[req.wr_addr] <= val;
      val1 <= val;
      shift1 <= req.shift;
    end
  end

  // running sum update and divide by window
  always_comb begin
    leaving = s1.hit ? rd_data : '0;
    sum_next = sum + SUM_W'(val1) - SUM_W'(leaving);
    quot = sum_next >> shift1;
    if (sum_next[SUM_W-1]) begin
      result = '0;
    end else if (quot > SUM_W'(SAMPLE_MAX)) begin
      result = SAMPLE_MAX;
    end else begin
      result = quot[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (s1.go) begin
      sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

### hdl/fcma_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module fcma_merge (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      go,
  input  wire fcma_pkg::sample_t [fcma_pkg::CHANNELS-1:0] result,
  output logic                                           out_free,
  output logic                                           smoothed_valid,
  input  wire logic                                      smoothed_ready,
  output fcma_pkg::sample_t [fcma_pkg::CHANNELS-1:0]      smoothed
);
  import fcma_pkg::*;

  // output register takes all four lanes at once
  assign out_free = !smoothed_valid || smoothed_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed_valid <= 1'b0;
    end else if (go) begin
      smoothed_valid <= 1'b1;
    end else if (smoothed_ready) begin
      smoothed_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int c = 0; c < CHANNELS; c++) begin
        smoothed[c] <= result[c];
      end
    end
  end

endmodule

`default_nettype wire

### hdl/four_channel_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                   payload
// ------------------------------------------------------------------------------
// config    psel penable pwrite paddr pwdata prdata   smoothing_mode at 0x0
// sample    sample_valid / sample_ready               cv, knob_a/b/c samples
// smoothed  smoothed_valid / smoothed_ready           cv, knob_a/b/c averages
//
// one scan item per cycle while sample_ready is high; each lane's history ram
// does one read and one write per cycle, so a step never waits on the ring.
// a taken item is held in stage 1, and its result is offered from the output
// register; in pre-average mode only every fourth item makes a step.
// reset is synchronous; the history is emptied at once by one valid bit per row,
// no clearing pass.
// a stalled output holds the result register and stage 1, which drops sample_ready.
module four_channel_moving_average (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fcma_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [fcma_pkg::APB_DATA_W-1:0] pwdata,
  output logic [fcma_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  wire logic                            sample_valid,
  output logic                                 sample_ready,
  input  wire logic [fcma_pkg::SAMPLE_W-1:0]   cv_sample,
  input  wire logic [fcma_pkg::SAMPLE_W-1:0]   knob_a_sample,
  input  wire logic [fcma_pkg::SAMPLE_W-1:0]   knob_b_sample,
  input  wire logic [fcma_pkg::SAMPLE_W-1:0]   knob_c_sample,
  output logic                                 smoothed_valid,
  input  wire logic                            smoothed_ready,
  output logic [fcma_pkg::SAMPLE_W-1:0]        cv_smoothed,
  output logic [fcma_pkg::SAMPLE_W-1:0]        knob_a_smoothed,
  output logic [fcma_pkg::SAMPLE_W-1:0]        knob_b_smoothed,
  output logic [fcma_pkg::SAMPLE_W-1:0]        knob_c_smoothed
);
  import fcma_pkg::*;

  logic [1:0] smoothing_mode;

  logic reg_sel;
  logic reg_write;
  sample_t [CHANNELS-1:0] scan;
  sample_t [CHANNELS-1:0] step_val;
  sample_t [CHANNELS-1:0] result;
  sample_t [CHANNELS-1:0] smoothed;
  lane_req_t cv_req;
  lane_req_t knob_req;
  lane_s1_t cv_s1;
  lane_s1_t knob_s1;
  logic out_free;

  // register port
  assign pready = 1'b1;
  assign reg_sel = (paddr[APB_ADDR_W-1:2] == REG_SMOOTHING_MODE);
  assign reg_write = psel && penable && pwrite && pready && reg_sel;
  assign prdata = reg_sel ? {{(APB_DATA_W-2){1'b0}}, smoothing_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_mode <= MODE_FAST;
    end else if (reg_write) begin
      smoothing_mode <= pwdata[1:0];
    end
  end

  // scan fields in lane order
  assign scan[0] = cv_sample;
  assign scan[1] = knob_a_sample;
  assign scan[2] = knob_b_sample;
  assign scan[3] = knob_c_sample;

  fcma_front u_front (
    .clk            (clk),
    .rst            (rst),
    .smoothing_mode (smoothing_mode),
    .sample_valid   (sample_valid),
    .sample_ready   (sample_ready),
    .scan           (scan),
    .out_free       (out_free),
    .step_val       (step_val),
    .cv_req         (cv_req),
    .knob_req       (knob_req),
    .cv_s1          (cv_s1),
    .knob_s1        (knob_s1)
  );

  // one averaging lane per channel
  fcma_lane u_lane_cv (
    .clk    (clk),
    .rst    (rst),
    .req    (cv_req),
    .val    (step_val[0]),
    .s1     (cv_s1),
    .result (result[0])
  );

  for (genvar c = 1; c < CHANNELS; c++) begin : g_knob
    fcma_lane u_lane_knob (
      .clk    (clk),
      .rst    (rst),
      .req    (knob_req),
      .val    (step_val[c]),
      .s1     (knob_s1),
      .result (result[c])
    );
  end

  fcma_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .go             (cv_s1.go),
    .result         (result),
    .out_free       (out_free),
    .smoothed_valid (smoothed_valid),
    .smoothed_ready (smoothed_ready),
    .smoothed       (smoothed)
  );

  assign cv_smoothed = smoothed[0];
  assign knob_a_smoothed = smoothed[1];
  assign knob_b_smoothed = smoothed[2];
  assign knob_c_smoothed = smoothed[3];

endmodule

`default_nettype wire
